@@ rtl/ssr_pkg.sv @@
// shared types and constants for the stream substring replace block
`default_nettype none

package ssr_pkg;

  localparam int CHAR_W   = 8;
  localparam int LEN_W    = 4;
  localparam int PACKED_W = 64;
  localparam int PACKED_N = 8;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_CHARS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REPLACE_LEN   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_REPLACE_CHARS = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              string_last;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              has_char;
    logic              run_last;
    logic              string_end;
  } out_item_t;

  // window cell control
  typedef struct packed {
    logic store;
    logic shift;
  } win_ctrl_t;

  // output slot control
  typedef struct packed {
    logic pop;
    logic load;
    logic from_prev;
  } out_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/ssr_stream_if.sv @@
// valid/ready stream channel carrying one payload struct
`default_nettype none

interface ssr_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/ssr_win_cell.sv @@
// one window cell: holds a pending character and compares it to its pattern character
`default_nettype none

module ssr_win_cell
  import ssr_pkg::*;
(
  input  wire logic              clk,
  input  wire win_ctrl_t         ctrl,
  input  wire logic              hit,
  input  wire logic [CHAR_W-1:0] new_char,
  input  wire logic [CHAR_W-1:0] nbr_ext,
  input  wire logic [CHAR_W-1:0] pat_char,
  output logic      [CHAR_W-1:0] ext_char,
  output logic                   eq
);

  logic [CHAR_W-1:0] held;

  // window contents with the incoming character placed at the write position
  assign ext_char = hit ? new_char : held;
  assign eq       = (ext_char == pat_char);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held <= nbr_ext;
    end else if (ctrl.store) begin
      held <= ext_char;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ssr_out_cell.sv @@
// one output slot: shifts toward the port or loads a result of a new burst
`default_nettype none

module ssr_out_cell
  import ssr_pkg::*;
(
  input  wire logic      clk,
  input  wire out_ctrl_t ctrl,
  input  wire out_item_t nbr,
  input  wire out_item_t own_burst,
  input  wire out_item_t prev_burst,
  output out_item_t      item
);

  out_item_t item_next;

  always_comb begin
    if (ctrl.load) begin
      item_next = ctrl.from_prev ? prev_burst : own_burst;
    end else if (ctrl.pop) begin
      item_next = nbr;
    end else begin
      item_next = item;
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
  end

endmodule

`default_nettype wire

@@ rtl/stream_substring_replace.sv @@
// top level: pattern window chain, burst builder and output slot chain
//
//   channel  dir  handshake       payload
//   char_ch  in   valid/ready     char_in, string_last
//   res_ch   out  valid/ready     char_out, has_char, run_last, string_end
//   cfg      in   cfg_we          cfg_index, cfg_data
//
// an item's results are built in the cycle it is accepted and land in the
// output slot chain, which drains one result per cycle from a register while
// res_ch is ready; a burst of results holds off the next item, as input is
// ready only while at most one result waits
// rst clears the window fill, the slot count and the configuration registers
`default_nettype none

module stream_substring_replace
  import ssr_pkg::*;
#(
  parameter int MAX_PATTERN = 8,
  parameter int MAX_REPLACE = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [PACKED_W-1:0]  cfg_data,
  ssr_stream_if.sink                char_ch,
  ssr_stream_if.source              res_ch
);

  localparam int WIN     = (MAX_PATTERN < PACKED_N) ? MAX_PATTERN : PACKED_N;
  localparam int RWIN    = (MAX_REPLACE < PACKED_N) ? MAX_REPLACE : PACKED_N;
  localparam int BURST   = (WIN > RWIN) ? WIN : RWIN;
  localparam int DEPTH   = BURST + 1;
  localparam int FILL_W  = $clog2(WIN + 1);
  localparam int RLEN_W  = $clog2(RWIN + 1);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  logic [LEN_W-1:0]    pattern_len;
  logic [PACKED_W-1:0] pattern_chars;
  logic [LEN_W-1:0]    replace_len;
  logic [PACKED_W-1:0] replace_chars;

  logic [FILL_W-1:0] fill, fill_next;
  logic [CNT_W-1:0]  count, count_next;

  logic [FILL_W-1:0] plen, eff_fill, fill_inc;
  logic [RLEN_W-1:0] rlen;
  logic              accept, pop, base, last, full, match, all_eq, bare;
  logic [CNT_W-1:0]  n;
  logic              pat_write;

  win_ctrl_t         wctrl;
  logic [CHAR_W-1:0] ext  [WIN];
  logic [WIN-1:0]    eq;
  out_item_t         burst [BURST];
  out_item_t         slot  [DEPTH];

  // configuration registers
  assign pat_write = cfg_we &&
                     ((cfg_index == REG_PATTERN_LEN) || (cfg_index == REG_PATTERN_CHARS));

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len   <= '0;
      pattern_chars <= '0;
      replace_len   <= '0;
      replace_chars <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LEN:   pattern_len   <= cfg_data[LEN_W-1:0];
        REG_PATTERN_CHARS: pattern_chars <= cfg_data;
        REG_REPLACE_LEN:   replace_len   <= cfg_data[LEN_W-1:0];
        REG_REPLACE_CHARS: replace_chars <= cfg_data;
        default: ;
      endcase
    end
  end

  assign plen = (pattern_len > LEN_W'(WIN)) ? FILL_W'(WIN) : FILL_W'(pattern_len);
  assign rlen = (replace_len > LEN_W'(RWIN)) ? RLEN_W'(RWIN) : RLEN_W'(replace_len);

  // handshake
  assign char_ch.ready = (count <= CNT_W'(1));
  assign accept        = char_ch.valid && char_ch.ready;
  assign last          = char_ch.data.string_last;
  assign res_ch.valid  = (count != '0);
  assign res_ch.data   = slot[0];
  assign pop           = (count != '0) && res_ch.ready;
  assign base          = (count != '0) && !pop;

  // window state
  assign eff_fill = (fill >= plen) ? '0 : fill;
  assign fill_inc = eff_fill + FILL_W'(1);
  assign full     = (plen != '0) && (fill_inc == plen);

  always_comb begin
    all_eq = 1'b1;
    for (int k = 0; k < WIN; k++) begin
      if ((FILL_W'(k) < plen) && !eq[k]) begin
        all_eq = 1'b0;
      end
    end
  end

  assign match = full && all_eq;
  assign bare  = match && (rlen == '0) && last;

  assign wctrl.store = accept;
  assign wctrl.shift = accept && full && !match && !last;

  genvar k;
  generate
    for (k = 0; k < WIN; k++) begin : g_win
      logic [CHAR_W-1:0] nbr;
      if (k == WIN - 1) begin : g_end
        assign nbr = '0;
      end else begin : g_mid
        assign nbr = ext[k+1];
      end
      ssr_win_cell u_cell (
        .clk      (clk),
        .ctrl     (wctrl),
        .hit      (eff_fill == FILL_W'(k)),
        .new_char (char_ch.data.char_in),
        .nbr_ext  (nbr),
        .pat_char (pattern_chars[k*CHAR_W +: CHAR_W]),
        .ext_char (ext[k]),
        .eq       (eq[k])
      );
    end
  endgenerate

  // number of results for the accepted item
  always_comb begin
    if (plen == '0) begin
      n = CNT_W'(1);
    end else if (match) begin
      n = (rlen == '0) ? (last ? CNT_W'(1) : '0) : CNT_W'(rlen);
    end else if (full) begin
      n = last ? CNT_W'(plen) : CNT_W'(1);
    end else begin
      n = last ? CNT_W'(fill_inc) : '0;
    end
  end

  always_comb begin
    if (pat_write || (accept && (last || (plen == '0) || match))) begin
      fill_next = '0;
    end else if (accept && full) begin
      fill_next = plen - FILL_W'(1);
    end else if (accept) begin
      fill_next = fill_inc;
    end else begin
      fill_next = fill;
    end
  end

  assign count_next = count - CNT_W'(pop) + (accept ? n : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      count <= '0;
    end else begin
      fill  <= fill_next;
      count <= count_next;
    end
  end

  // burst of results, slot j of the burst is result j of the item
  genvar j;
  generate
    for (j = 0; j < BURST; j++) begin : g_burst
      logic [CHAR_W-1:0] rep_c, win_c;
      logic              at_end;
      if (j < RWIN) begin : g_rep
        assign rep_c = replace_chars[j*CHAR_W +: CHAR_W];
      end else begin : g_norep
        assign rep_c = '0;
      end
      if (j < WIN) begin : g_w
        assign win_c = ext[j];
      end else begin : g_now
        assign win_c = '0;
      end
      assign at_end = (CNT_W'(j) + CNT_W'(1) == n);
      assign burst[j].char_out   = bare ? '0 : (match ? rep_c : win_c);
      assign burst[j].has_char   = !bare;
      assign burst[j].run_last   = at_end;
      assign burst[j].string_end = at_end && last;
    end

    for (j = 0; j < DEPTH; j++) begin : g_slot
      out_item_t nbr, own_b, prev_b;
      out_ctrl_t sctrl;
      if (j == DEPTH - 1) begin : g_last
        assign nbr   = '0;
        assign own_b = '0;
      end else begin : g_inner
        assign nbr   = slot[j+1];
        assign own_b = burst[j];
      end
      if (j == 0) begin : g_first
        assign prev_b    = '0;
        assign sctrl.load = accept && !base;
      end else begin : g_rest
        assign prev_b    = burst[j-1];
        assign sctrl.load = accept;
      end
      assign sctrl.pop       = pop;
      assign sctrl.from_prev = base;
      ssr_out_cell u_slot (
        .clk        (clk),
        .ctrl       (sctrl),
        .nbr        (nbr),
        .own_burst  (own_b),
        .prev_burst (prev_b),
        .item       (slot[j])
      );
    end
  endgenerate

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// testbench for stream_substring_replace: table of directed strings, then random strings
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssr_pkg::*;

  localparam int MAX_CHARS    = 8;
  localparam int RANDOM_ITEMS = 370;
  localparam int IDLE_PAD     = 12;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [REG_IDX_W-1:0] idx;
    logic [PACKED_W-1:0]  data;
    logic [CHAR_W-1:0]    ch;
    logic                 last;
    bit                   fixed;
    out_item_t            want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [PACKED_W-1:0]  cfg_data = '0;

  ssr_stream_if #(.T(in_item_t))  char_ch ();
  ssr_stream_if #(.T(out_item_t)) res_ch ();

  stream_substring_replace u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .char_ch   (char_ch),
    .res_ch    (res_ch)
  );

  always #5 clk = ~clk;

  // shadow of the block's registers and search window
  logic [CHAR_W-1:0]   win_chars [MAX_CHARS];
  int unsigned         win_fill = 0;
  logic [LEN_W-1:0]    plen_reg = '0;
  logic [LEN_W-1:0]    rlen_reg = '0;
  logic [PACKED_W-1:0] pchars_reg = '0;
  logic [PACKED_W-1:0] rchars_reg = '0;

  out_item_t  step_chars[$];
  out_item_t  emit_q[$];
  stim_row_t  dir_rows[$];
  out_item_t  got_r, want_r;
  int         bad_cnt = 0;
  int         cycle_cnt = 0;
  bit         burst_mode = 1'b0;

  function automatic out_item_t mk_res(logic [CHAR_W-1:0] c, logic has, logic rl, logic se);
    out_item_t r;
    r.char_out   = c;
    r.has_char   = has;
    r.run_last   = rl;
    r.string_end = se;
    return r;
  endfunction

  function automatic int sat_len(logic [LEN_W-1:0] v);
    return (v > MAX_CHARS) ? MAX_CHARS : int'(v);
  endfunction

  function automatic logic [CHAR_W-1:0] char_at(logic [PACKED_W-1:0] p, int k);
    return p[k*CHAR_W +: CHAR_W];
  endfunction

  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 5);
  endfunction

  // characters emitted for one accepted source character, into step_chars
  function automatic void apply_replace(logic [CHAR_W-1:0] c, logic last);
    int        plen;
    int        rlen;
    bit        hit;
    out_item_t tail;
    plen = sat_len(plen_reg);
    rlen = sat_len(rlen_reg);
    step_chars.delete();
    if (plen == 0) begin
      win_fill = 0;
      step_chars.push_back(mk_res(c, 1'b1, 1'b0, 1'b0));
    end else begin
      if (win_fill >= plen) win_fill = 0;
      win_chars[win_fill] = c;
      win_fill++;
      if (win_fill == plen) begin
        hit = 1'b1;
        for (int k = 0; k < plen; k++)
          if (win_chars[k] != char_at(pchars_reg, k)) hit = 1'b0;
        if (hit) begin
          for (int k = 0; k < rlen; k++)
            step_chars.push_back(mk_res(char_at(rchars_reg, k), 1'b1, 1'b0, 1'b0));
          win_fill = 0;
        end else begin
          step_chars.push_back(mk_res(win_chars[0], 1'b1, 1'b0, 1'b0));
          for (int k = 1; k < plen; k++) win_chars[k-1] = win_chars[k];
          win_fill--;
        end
      end
      if (last) begin
        for (int k = 0; k < win_fill; k++)
          step_chars.push_back(mk_res(win_chars[k], 1'b1, 1'b0, 1'b0));
        win_fill = 0;
      end
    end
    // nothing left to emit on the last character: bare end marker
    if (last && step_chars.size() == 0)
      step_chars.push_back(mk_res('0, 1'b0, 1'b0, 1'b0));
    if (step_chars.size() > 0) begin
      tail = step_chars.pop_back();
      tail.run_last = 1'b1;
      if (last) tail.string_end = 1'b1;
      step_chars.push_back(tail);
    end
  endfunction

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [PACKED_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PATTERN_LEN: begin
        plen_reg = val[LEN_W-1:0];
        win_fill = 0;
      end
      REG_PATTERN_CHARS: begin
        pchars_reg = val;
        win_fill   = 0;
      end
      REG_REPLACE_LEN:   rlen_reg   = val[LEN_W-1:0];
      REG_REPLACE_CHARS: rchars_reg = val;
      default: ;
    endcase
  endtask

  // one source character; a fixed row supplies its own single expected result
  task automatic send_char(logic [CHAR_W-1:0] c, logic last, bit fixed, out_item_t want);
    int       gap;
    in_item_t it;
    gap = draw_gap();
    it.char_in     = c;
    it.string_last = last;
    if (gap > 0) begin
      @(negedge clk);
      char_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    char_ch.valid <= 1'b1;
    char_ch.data  <= it;
    do @(posedge clk); while (!char_ch.ready);
    apply_replace(c, last);
    if (fixed) emit_q.push_back(want);
    else foreach (step_chars[i]) emit_q.push_back(step_chars[i]);
  endtask

  // drop valid and wait for the block to drain
  task automatic settle();
    @(negedge clk);
    char_ch.valid <= 1'b0;
    while (emit_q.size() != 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic add_cfg(logic [REG_IDX_W-1:0] idx, logic [PACKED_W-1:0] val);
    stim_row_t r;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.data  = val;
    r.ch    = '0;
    r.last  = 1'b0;
    r.fixed = 1'b0;
    r.want  = '0;
    dir_rows.push_back(r);
  endtask

  task automatic add_item(logic [CHAR_W-1:0] c, logic last, bit fixed, out_item_t want);
    stim_row_t r;
    r.kind  = ROW_ITEM;
    r.idx   = '0;
    r.data  = '0;
    r.ch    = c;
    r.last  = last;
    r.fixed = fixed;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  initial begin
    char_ch.valid = 1'b0;
    char_ch.data  = '0;
    res_ch.ready  = 1'b0;
  end

  // result side back-pressure
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = draw_gap();
      repeat (stall) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
      end
      @(negedge clk);
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      got_r = res_ch.data;
      if (emit_q.size() == 0) begin
        bad_cnt++;
        $display("%0t: unexpected result, expected none, actual char %h has %b run %b end %b",
                 $time, got_r.char_out, got_r.has_char, got_r.run_last, got_r.string_end);
      end else begin
        want_r = emit_q.pop_front();
        if (got_r.char_out !== want_r.char_out || got_r.has_char !== want_r.has_char ||
            got_r.run_last !== want_r.run_last || got_r.string_end !== want_r.string_end) begin
          bad_cnt++;
          $display({"%0t: result mismatch, expected char %h has %b run %b end %b, ",
                    "actual char %h has %b run %b end %b"},
                   $time, want_r.char_out, want_r.has_char, want_r.run_last, want_r.string_end,
                   got_r.char_out, got_r.has_char, got_r.run_last, got_r.string_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int                  sent;
    int                  n;
    int                  k;
    int                  sel;
    int                  pl;
    int                  cut;
    logic [PACKED_W-1:0] lval;
    logic [PACKED_W-1:0] pat;
    logic [CHAR_W-1:0]   a0;
    logic [CHAR_W-1:0]   a1;
    logic [CHAR_W-1:0]   frag[$];

    foreach (win_chars[i]) win_chars[i] = '0;

    // pass through after reset
    add_item(8'h00, 1'b0, 1'b1, mk_res(8'h00, 1'b1, 1'b1, 1'b0));
    add_item(8'hFF, 1'b1, 1'b1, mk_res(8'hFF, 1'b1, 1'b1, 1'b1));
    add_item(8'h5A, 1'b0, 1'b1, mk_res(8'h5A, 1'b1, 1'b1, 1'b0));
    // "ab" -> "XYZ"
    add_cfg(REG_PATTERN_CHARS, 64'h6261);
    add_cfg(REG_PATTERN_LEN,   64'd2);
    add_cfg(REG_REPLACE_CHARS, 64'h5A5958);
    add_cfg(REG_REPLACE_LEN,   64'd3);
    add_item(8'h61, 1'b0, 1'b0, '0);
    add_item(8'h62, 1'b0, 1'b0, '0);
    add_item(8'h61, 1'b0, 1'b0, '0);
    add_item(8'h63, 1'b1, 1'b0, '0);
    // delete matches; a match on the last character leaves a bare end marker
    add_cfg(REG_REPLACE_LEN, 64'd0);
    add_item(8'h61, 1'b0, 1'b0, '0);
    add_item(8'h62, 1'b0, 1'b0, '0);
    add_item(8'h61, 1'b0, 1'b0, '0);
    add_item(8'h62, 1'b1, 1'b1, mk_res(8'h00, 1'b0, 1'b1, 1'b1));
    // oversized lengths saturate at eight
    add_cfg(REG_PATTERN_LEN,   64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(REG_PATTERN_CHARS, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(REG_REPLACE_LEN,   64'hF0F0_F0F0_F0F0_F0FF);
    add_cfg(REG_REPLACE_CHARS, 64'hFF00_8040_2010_0801);
    repeat (8) add_item(8'hFF, 1'b0, 1'b0, '0);
    add_item(8'h00, 1'b1, 1'b1, mk_res(8'h00, 1'b1, 1'b1, 1'b1));
    // new pattern mid-string drops the held characters
    repeat (3) add_item(8'hFF, 1'b0, 1'b0, '0);
    add_cfg(REG_PATTERN_CHARS, 64'hFFFF_FFFF_FFFF_FF41);
    add_item(8'h41, 1'b1, 1'b1, mk_res(8'h41, 1'b1, 1'b1, 1'b1));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].fixed, dir_rows[i].want);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      burst_mode = ($urandom_range(0, 3) == 0);
      a0 = CHAR_W'($urandom_range(0, 255));
      a1 = CHAR_W'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) begin
        pat = {$urandom, $urandom};
      end else begin
        for (int j = 0; j < MAX_CHARS; j++)
          pat[j*CHAR_W +: CHAR_W] = $urandom_range(0, 1) ? a0 : a1;
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_PATTERN_CHARS, pat);
      if ($urandom_range(0, 3) != 0) begin
        lval = {$urandom, $urandom};
        case ($urandom_range(0, 5))
          0:       lval[LEN_W-1:0] = 4'd0;
          1:       lval[LEN_W-1:0] = 4'd8;
          2:       lval[LEN_W-1:0] = LEN_W'($urandom_range(9, 15));
          default: lval[LEN_W-1:0] = LEN_W'($urandom_range(1, 4));
        endcase
        write_reg(REG_PATTERN_LEN, lval);
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_REPLACE_CHARS, {$urandom, $urandom});
      if ($urandom_range(0, 3) != 0) begin
        lval = {$urandom, $urandom};
        case ($urandom_range(0, 5))
          0:       lval[LEN_W-1:0] = 4'd0;
          1:       lval[LEN_W-1:0] = 4'd8;
          2:       lval[LEN_W-1:0] = LEN_W'($urandom_range(9, 15));
          default: lval[LEN_W-1:0] = LEN_W'($urandom_range(1, 4));
        endcase
        write_reg(REG_REPLACE_LEN, lval);
      end

      n  = $urandom_range(30, 60);
      k  = 0;
      pl = sat_len(plen_reg);
      while (k < n) begin
        frag.delete();
        sel = $urandom_range(0, 9);
        if (sel < 4 && pl > 0) begin
          for (int j = 0; j < pl; j++) frag.push_back(char_at(pchars_reg, j));
        end else if (sel < 6 && pl > 1) begin
          // partial match followed by a random character
          cut = $urandom_range(1, pl - 1);
          for (int j = 0; j < cut; j++) frag.push_back(char_at(pchars_reg, j));
          frag.push_back(CHAR_W'($urandom_range(0, 255)));
        end else if (sel < 8 && pl > 0) begin
          frag.push_back(char_at(pchars_reg, $urandom_range(0, pl - 1)));
        end else begin
          frag.push_back(CHAR_W'($urandom_range(0, 255)));
        end
        foreach (frag[j]) begin
          send_char(frag[j], ($urandom_range(0, 11) == 0), 1'b0, '0);
          sent++;
          k++;
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (bad_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
